// ===== hw/rtl/scl1_pkg.sv =====
// Shared types and constants for the scaled codebook L1 search.
// No dependencies.
`timescale 1ns / 1ps
package scl1_pkg;
   localparam int Entries    = 32;
   localparam int MaxSamples = 64;
   localparam int EntW       = $clog2(Entries);
   localparam int PosW       = $clog2(MaxSamples);
   localparam int AddrW      = EntW + PosW;
   localparam int GainLimit  = 100;

   typedef enum logic [1:0] {
      OP_LOAD_PATTERN = 2'd0,
      OP_LOAD_TAG     = 2'd1,
      OP_LOAD_WINDOW  = 2'd2,
      OP_SEARCH       = 2'd3
   } op_type;

   localparam logic [0:0] REG_WINDOW_LENGTH  = 1'b0;
   localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b1;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage

// ===== hw/rtl/scl1_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on scl1_pkg.
`timescale 1ns / 1ps
module scl1_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  scl1_pkg::div_req_type req,
   output scl1_pkg::div_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic        neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff; count_in = count_ff; rem_in = rem_ff;
      quo_in = quo_ff; dsr_in = dsr_ff; neg_in = neg_ff; done_in = 1'b0;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = 6'd32;
         rem_in   = '0;
         quo_in   = req.dividend[31] ? -req.dividend : req.dividend;
         dsr_in   = req.divisor[31] ? -req.divisor : req.divisor;
         neg_in   = req.dividend[31] ^ req.divisor[31];
      end else if (busy_ff) begin
         // shift-subtract one bit
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) quo_in = -quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; count_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; count_ff <= count_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; neg_ff <= neg_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

`ifndef NO_ASSERTIONS
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !req.start |-> count_ff != 6'd0) else $error("divider count underflow");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("divider did not start");
`endif
endmodule

// ===== hw/rtl/scaled_codebook_l1_search.sv =====
// Top level of the scaled codebook L1 search: stores, sequencer, result register.
// Depends on scl1_pkg and scl1_divider.
//
// Usage: req_ carries one word per handshake. Opcodes 0..2 load a pattern
// sample, an entry tag or a window sample and give no result. Opcode 3
// searches entries 0..min(entries_in_use, 32)-1 whose tag equals the channel
// and returns one rsp_ word. For each entry the sequencer reads the tag; for
// a matching entry it sums the window and pattern over window_length L
// samples (L clamped to 64), runs up to two divisions on the shared divider,
// accumulates the L1 distance with one multiplier and compares. req_ready
// is low for the whole search and while a result waits in the output
// register; a stalled receiver holds the block. Reset clears control state
// and sets window_length to 64 and entries_in_use to 32; the stores are
// undefined until written. csr_ writes take effect at once; issue them only
// while idle.
`timescale 1ns / 1ps
module scaled_codebook_l1_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_entry_index,
   input  logic [5:0]  req_sample_index,
   input  logic signed [15:0] req_sample_value,
   input  logic [7:0]  req_tag_or_channel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [4:0]  rsp_best_entry,
   output logic [6:0]  rsp_best_scale,
   output logic [27:0] rsp_best_distance,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [6:0]  csr_write_data
);
   localparam int EW = scl1_pkg::EntW;
   localparam int PW = scl1_pkg::PosW;

   typedef enum logic [3:0] {
      S_IDLE, S_TAG, S_TAGCHK, S_SUM, S_MEAN, S_MEANW, S_QUOT, S_QUOTW,
      S_DIST, S_CMP, S_RESP
   } state_type;

   logic signed [15:0] pattern_mem [scl1_pkg::Entries*scl1_pkg::MaxSamples];
   logic [7:0]         tag_mem [scl1_pkg::Entries];
   logic signed [15:0] window_mem [scl1_pkg::MaxSamples];

   state_type   state_ff;
   logic [6:0]  wlen_ff;
   logic [5:0]  used_ff;
   logic [7:0]  chan_ff;
   logic [EW:0] ent_ff;
   logic [PW:0] pos_ff;
   logic        rd_ok_ff;
   logic signed [15:0] pat_rd_ff, win_rd_ff;
   logic [7:0]  tag_rd_ff;
   logic signed [31:0] wsum_ff, psum_ff, mean_ff;
   logic [6:0]  gain_ff;
   logic signed [32:0] prod_ff;
   logic [33:0] dist_ff;
   logic        found_ff, rsp_valid_ff;
   logic [4:0]  best_e_ff;
   logic [6:0]  best_g_ff;
   logic [33:0] best_d_ff;
   scl1_pkg::div_req_type div_req;
   scl1_pkg::div_rsp_type div_rsp;

   logic [6:0]  len;
   logic [EW:0] count;
   logic        accept;
   logic        rd_en;
   logic [PW-1:0] rd_pos;
   logic signed [15:0] q16;

   assign len   = (wlen_ff > 7'(scl1_pkg::MaxSamples)) ? 7'(scl1_pkg::MaxSamples) : wlen_ff;
   assign count = ({1'b0, used_ff} > 7'(scl1_pkg::Entries)) ? (EW+1)'(scl1_pkg::Entries)
                                                         : (EW+1)'(used_ff);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rd_pos    = pos_ff[PW-1:0];
   assign rd_en     = (state_ff == S_SUM || state_ff == S_DIST) && (pos_ff < (PW+1)'(len));
   assign q16       = div_rsp.quotient[15:0];

   // stores
   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (scl1_pkg::op_type'(req_opcode))
            scl1_pkg::OP_LOAD_PATTERN:
               pattern_mem[{req_entry_index, req_sample_index}] <= req_sample_value;
            scl1_pkg::OP_LOAD_TAG:    tag_mem[req_entry_index] <= req_tag_or_channel;
            scl1_pkg::OP_LOAD_WINDOW: window_mem[req_sample_index] <= req_sample_value;
            default: ;
         endcase
      end
      pat_rd_ff <= pattern_mem[{ent_ff[EW-1:0], rd_pos}];
      win_rd_ff <= window_mem[rd_pos];
      tag_rd_ff <= tag_mem[ent_ff[EW-1:0]];
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = psum_ff;
      div_req.divisor  = 32'(len);
      if (state_ff == S_MEAN) div_req.start = 1'b1;
      if (state_ff == S_QUOT && mean_ff != 0) begin
         div_req.start    = 1'b1;
         div_req.dividend = wsum_ff;
         div_req.divisor  = mean_ff;
      end
   end

   scl1_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_en;
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0;
         wlen_ff <= 7'd64; used_ff <= 6'd32;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == scl1_pkg::REG_WINDOW_LENGTH) wlen_ff <= csr_write_data;
            else used_ff <= csr_write_data[5:0];
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (accept && req_opcode == scl1_pkg::OP_SEARCH) begin
               chan_ff <= req_tag_or_channel; ent_ff <= '0; found_ff <= 1'b0;
               best_e_ff <= '0; best_g_ff <= 7'd1; best_d_ff <= 34'h7FFFFFFF;
               state_ff <= S_TAG;
            end
            S_TAG: state_ff <= (ent_ff < count) ? S_TAGCHK : S_RESP;
            S_TAGCHK: begin
               pos_ff <= '0; wsum_ff <= '0; psum_ff <= '0;
               if (tag_rd_ff == chan_ff) state_ff <= S_SUM;
               else begin ent_ff <= ent_ff + 1'b1; state_ff <= S_TAG; end
            end
            S_SUM: begin
               // advance read address, fold in the previous word
               if (rd_en) pos_ff <= pos_ff + 1'b1;
               if (rd_ok_ff) begin
                  wsum_ff <= wsum_ff + 32'(win_rd_ff);
                  psum_ff <= psum_ff + 32'(pat_rd_ff);
               end
               if (!rd_en && !rd_ok_ff) state_ff <= S_MEAN;
            end
            S_MEAN: begin
               gain_ff <= 7'd1;
               state_ff <= (psum_ff != 0 && len != 0) ? S_MEANW : S_DIST;
               pos_ff <= '0; dist_ff <= '0; prod_ff <= '0;
            end
            S_MEANW: if (div_rsp.done) begin
               mean_ff <= div_rsp.quotient; state_ff <= S_QUOT;
            end
            S_QUOT: state_ff <= (mean_ff != 0) ? S_QUOTW : S_DIST;
            S_QUOTW: if (div_rsp.done) begin
               if (q16 < 16'sd1) gain_ff <= 7'd1;
               else if (q16 > 16'(scl1_pkg::GainLimit)) gain_ff <= 7'(scl1_pkg::GainLimit);
               else gain_ff <= q16[6:0];
               state_ff <= S_DIST;
            end
            S_DIST: begin
               if (rd_en) pos_ff <= pos_ff + 1'b1;
               prod_ff <= rd_ok_ff ? 33'(win_rd_ff) - 33'(pat_rd_ff) * $signed({1'b0, gain_ff})
                                  : '0;
               dist_ff <= dist_ff + (prod_ff[32] ? 34'(-prod_ff) : 34'(prod_ff));
               if (!rd_en && !rd_ok_ff && prod_ff == 0) state_ff <= S_CMP;
            end
            S_CMP: begin
               if (dist_ff < best_d_ff) begin
                  best_d_ff <= dist_ff; best_e_ff <= ent_ff[4:0];
                  best_g_ff <= gain_ff; found_ff <= 1'b1;
               end
               ent_ff <= ent_ff + 1'b1; state_ff <= S_TAG;
            end
            S_RESP: begin rsp_valid_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_best_entry    = found_ff ? best_e_ff : 5'd0;
   assign rsp_best_scale    = found_ff ? best_g_ff : 7'd1;
   assign rsp_best_distance = found_ff ? best_d_ff[27:0] : 28'd0;

`ifndef NO_ASSERTIONS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready during search");
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> gain_ff >= 7'd1 && gain_ff <= 7'd100) else $error("gain range");
   a_resp_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> rsp_valid_ff) else $error("response lost");
`endif
endmodule
